>>> hdl/iat_pkg.sv
// iat_pkg: shared types, codes and helper functions for the address-to-text block
// used by iat_ctrl, iat_dp and ip_address_to_text; no dependencies
`default_nettype none
package iat_pkg;

  localparam logic [1:0] FAM_V4 = 2'd0;
  localparam logic [1:0] FAM_V6 = 2'd1;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_SMALL  = 2'd1;
  localparam logic [1:0] ST_FAMILY = 2'd2;

  localparam logic [6:0] V4_MIN_CAP = 7'd16;

  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_A     = 8'h61;

  localparam int         CNT_W    = 6;

  typedef enum logic [2:0] {
    C_IDLE,
    C_ANALYSE,
    C_INIT,
    C_COUNT,
    C_EMIT,
    C_ERR
  } ctrl_state_t;

  typedef enum logic [2:0] {
    G_SEP,
    G_COMP,
    G_HEX,
    G_DEC,
    G_DOT,
    G_TAIL,
    G_DONE
  } gen_ph_t;

  typedef struct packed {
    logic load;
    logic analyse;
    logic gen_init;
    logic gen_step;
    logic cnt_clr;
    logic out_char;
    logic out_err;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
    logic err;
    logic out_free;
  } dp_sts_t;

  typedef struct packed {
    logic       vld;
    logic [2:0] base;
    logic [3:0] len;
  } run_t;

  // first longest run of zero groups, two or more long
  function automatic run_t zero_run_f(input logic [7:0] z);
    run_t       b;
    logic       cv;
    logic [2:0] cb;
    logic [3:0] cl;
    b  = '0;
    cv = 1'b0;
    cb = 3'd0;
    cl = 4'd0;
    for (int i = 0; i < 8; i++) begin
      if (z[i]) begin
        if (!cv) begin
          cv = 1'b1;
          cb = 3'(i);
          cl = 4'd1;
        end else begin
          cl = cl + 4'd1;
        end
      end else if (cv) begin
        if (!b.vld || cl > b.len) begin
          b.vld  = 1'b1;
          b.base = cb;
          b.len  = cl;
        end
        cv = 1'b0;
      end
    end
    if (cv && (!b.vld || cl > b.len)) begin
      b.vld  = 1'b1;
      b.base = cb;
      b.len  = cl;
    end
    if (b.vld && b.len < 4'd2) begin
      b.vld = 1'b0;
    end
    return b;
  endfunction

  // byte to three bcd digits, hundreds in the top nibble
  function automatic logic [11:0] bcd_f(input logic [7:0] v);
    logic [19:0] s;
    s = {12'd0, v};
    for (int i = 0; i < 8; i++) begin
      if (s[11:8] >= 4'd5) s[11:8] = s[11:8] + 4'd3;
      if (s[15:12] >= 4'd5) s[15:12] = s[15:12] + 4'd3;
      if (s[19:16] >= 4'd5) s[19:16] = s[19:16] + 4'd3;
      s = s << 1;
    end
    return s[19:8];
  endfunction

endpackage
`default_nettype wire

>>> hdl/iat_ctrl.sv
// iat_ctrl: sequencing state machine for the address-to-text block
// depends on iat_pkg; drives iat_dp through command and status structs
`default_nettype none
module iat_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire iat_pkg::dp_sts_t sts,
  output iat_pkg::dp_cmd_t     cmd
);

  iat_pkg::ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= iat_pkg::C_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      iat_pkg::C_IDLE: begin
        if (in_valid) state_nxt = iat_pkg::C_ANALYSE;
      end
      iat_pkg::C_ANALYSE: state_nxt = iat_pkg::C_INIT;
      iat_pkg::C_INIT:    state_nxt = iat_pkg::C_COUNT;
      iat_pkg::C_COUNT: begin
        if (sts.done) state_nxt = sts.err ? iat_pkg::C_ERR : iat_pkg::C_EMIT;
      end
      iat_pkg::C_EMIT: begin
        if (sts.done) state_nxt = iat_pkg::C_IDLE;
      end
      iat_pkg::C_ERR: begin
        if (sts.out_free) state_nxt = iat_pkg::C_IDLE;
      end
      default: state_nxt = iat_pkg::C_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      iat_pkg::C_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      iat_pkg::C_ANALYSE: cmd.analyse = 1'b1;
      iat_pkg::C_INIT: begin
        cmd.gen_init = 1'b1;
        cmd.cnt_clr  = 1'b1;
      end
      iat_pkg::C_COUNT: begin
        cmd.gen_step = !sts.done;
        cmd.gen_init = sts.done;
      end
      iat_pkg::C_EMIT: begin
        cmd.gen_step = !sts.done && sts.out_free;
        cmd.out_char = !sts.done && sts.out_free;
      end
      iat_pkg::C_ERR: cmd.out_err = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

>>> hdl/iat_dp.sv
// iat_dp: address registers, zero-run analysis, character generator and output register
// depends on iat_pkg; commanded by iat_ctrl
`default_nettype none
module iat_dp (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire iat_pkg::dp_cmd_t cmd,
  output iat_pkg::dp_sts_t      sts,
  input  wire logic [1:0]       in_action,
  input  wire logic [63:0]      in_addr_high,
  input  wire logic [63:0]      in_addr_low,
  input  wire logic [6:0]       in_dest_capacity,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [7:0]            out_char_out,
  output logic                  out_last,
  output logic [1:0]            out_status
);

  typedef struct packed {
    iat_pkg::gen_ph_t ph;
    logic [3:0]       gi;
    logic [1:0]       np;
    logic [1:0]       bi;
    logic [1:0]       dp;
  } gen_t;

  logic [1:0]             fam_r;
  logic [6:0]             cap_r;
  logic [15:0]            words_r [8];
  logic [31:0]            quad_r;
  iat_pkg::run_t          run_r;
  gen_t                   gen_r, gen_nxt, ini, stp;
  logic [iat_pkg::CNT_W-1:0] cnt_r;
  logic                   out_valid_r;
  logic [7:0]             char_r;
  logic                   last_r;
  logic [1:0]             status_r;

  logic [7:0]  zflags;
  logic [15:0] cur_word;
  logic [7:0]  cur_byte;
  logic [11:0] cur_bcd;
  logic [3:0]  dig;
  logic [3:0]  nib;
  logic [7:0]  ch;
  logic        quad_form;
  logic        out_free;
  logic [1:0]  err_code;
  logic        err;

  function automatic logic [1:0] nib_start_f(input logic [15:0] w);
    logic [1:0] s;
    if (w[15:12] != 4'd0)      s = 2'd3;
    else if (w[11:8] != 4'd0)  s = 2'd2;
    else if (w[7:4] != 4'd0)   s = 2'd1;
    else                       s = 2'd0;
    return s;
  endfunction

  function automatic logic [1:0] dec_start_f(input logic [7:0] b);
    logic [11:0] d;
    logic [1:0]  s;
    d = iat_pkg::bcd_f(b);
    if (d[11:8] != 4'd0)      s = 2'd2;
    else if (d[7:4] != 4'd0)  s = 2'd1;
    else                      s = 2'd0;
    return s;
  endfunction

  function automatic gen_t enter_f(input logic [3:0] g, input iat_pkg::run_t r,
                                   input gen_t base);
    gen_t n;
    n    = base;
    n.gi = g;
    if (g[3]) begin
      n.ph = (r.vld && ({1'b0, r.base} + r.len == 4'd8)) ? iat_pkg::G_TAIL
                                                        : iat_pkg::G_DONE;
    end else if (r.vld && g[2:0] == r.base) begin
      n.ph = iat_pkg::G_COMP;
    end else begin
      n.ph = iat_pkg::G_SEP;
    end
    return n;
  endfunction

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      zflags[i] = (words_r[i] == 16'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      fam_r <= in_action;
      cap_r <= in_dest_capacity;
      for (int i = 0; i < 4; i++) begin
        words_r[i]     <= in_addr_high[16*(3-i) +: 16];
        words_r[i + 4] <= in_addr_low[16*(3-i) +: 16];
      end
      quad_r <= (in_action == iat_pkg::FAM_V4) ? in_addr_high[63:32] : in_addr_low[31:0];
    end
    if (cmd.analyse) begin
      run_r <= iat_pkg::zero_run_f(zflags);
    end
  end

  // generator
  assign cur_word = words_r[gen_r.gi[2:0]];

  always_comb begin
    case (gen_r.bi)
      2'd0:    cur_byte = quad_r[31:24];
      2'd1:    cur_byte = quad_r[23:16];
      2'd2:    cur_byte = quad_r[15:8];
      default: cur_byte = quad_r[7:0];
    endcase
  end

  assign cur_bcd = iat_pkg::bcd_f(cur_byte);

  always_comb begin
    case (gen_r.dp)
      2'd0:    dig = cur_bcd[3:0];
      2'd1:    dig = cur_bcd[7:4];
      default: dig = cur_bcd[11:8];
    endcase
  end

  always_comb begin
    case (gen_r.np)
      2'd0:    nib = cur_word[3:0];
      2'd1:    nib = cur_word[7:4];
      2'd2:    nib = cur_word[11:8];
      default: nib = cur_word[15:12];
    endcase
  end

  assign quad_form = (gen_r.gi == 4'd6) && run_r.vld && (run_r.base == 3'd0) &&
                     ((run_r.len == 4'd6) ||
                      ((run_r.len == 4'd5) && (words_r[5] == 16'hffff)));

  always_comb begin
    ini    = gen_r;
    ini.gi = 4'd0;
    ini.np = nib_start_f(words_r[0]);
    ini.bi = 2'd0;
    ini.dp = dec_start_f(quad_r[31:24]);
    if (fam_r == iat_pkg::FAM_V4) begin
      ini.ph = iat_pkg::G_DEC;
    end else if (run_r.vld && run_r.base == 3'd0) begin
      ini.ph = iat_pkg::G_COMP;
    end else begin
      ini.ph = iat_pkg::G_HEX;
    end
  end

  always_comb begin
    stp = gen_r;
    ch  = 8'd0;
    case (gen_r.ph)
      iat_pkg::G_COMP: begin
        ch  = iat_pkg::CH_COLON;
        stp = enter_f(gen_r.gi + run_r.len, run_r, gen_r);
      end
      iat_pkg::G_SEP: begin
        ch = iat_pkg::CH_COLON;
        if (quad_form) begin
          stp.ph = iat_pkg::G_DEC;
          stp.bi = 2'd0;
          stp.dp = dec_start_f(quad_r[31:24]);
        end else begin
          stp.ph = iat_pkg::G_HEX;
          stp.np = nib_start_f(cur_word);
        end
      end
      iat_pkg::G_HEX: begin
        ch = (nib < 4'd10) ? (iat_pkg::CH_ZERO + {4'd0, nib})
                           : (iat_pkg::CH_A + {4'd0, nib} - 8'd10);
        if (gen_r.np == 2'd0) stp = enter_f(gen_r.gi + 4'd1, run_r, gen_r);
        else                  stp.np = gen_r.np - 2'd1;
      end
      iat_pkg::G_DEC: begin
        ch = iat_pkg::CH_ZERO + {4'd0, dig};
        if (gen_r.dp == 2'd0) begin
          if (gen_r.bi == 2'd3) begin
            stp.ph = iat_pkg::G_DONE;
          end else begin
            stp.ph = iat_pkg::G_DOT;
            stp.bi = gen_r.bi + 2'd1;
          end
        end else begin
          stp.dp = gen_r.dp - 2'd1;
        end
      end
      iat_pkg::G_DOT: begin
        ch     = iat_pkg::CH_DOT;
        stp.ph = iat_pkg::G_DEC;
        stp.dp = dec_start_f(cur_byte);
      end
      iat_pkg::G_TAIL: begin
        ch     = iat_pkg::CH_COLON;
        stp.ph = iat_pkg::G_DONE;
      end
      default: begin
        ch  = 8'd0;
        stp = gen_r;
      end
    endcase
  end

  always_comb begin
    gen_nxt = gen_r;
    if (cmd.gen_init)      gen_nxt = ini;
    else if (cmd.gen_step) gen_nxt = stp;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_r.ph <= iat_pkg::G_DONE;
    end else begin
      gen_r.ph <= gen_nxt.ph;
    end
    gen_r.gi <= gen_nxt.gi;
    gen_r.np <= gen_nxt.np;
    gen_r.bi <= gen_nxt.bi;
    gen_r.dp <= gen_nxt.dp;
  end

  // text length and capacity check
  always_ff @(posedge clk) begin
    if (cmd.cnt_clr) begin
      cnt_r <= '0;
    end else if (cmd.gen_step && !cmd.out_char) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  always_comb begin
    err_code = iat_pkg::ST_OK;
    if (fam_r != iat_pkg::FAM_V4 && fam_r != iat_pkg::FAM_V6) begin
      err_code = iat_pkg::ST_FAMILY;
    end else if (fam_r == iat_pkg::FAM_V4) begin
      if (cap_r < iat_pkg::V4_MIN_CAP) err_code = iat_pkg::ST_SMALL;
    end else if ({1'b0, cnt_r} >= cap_r) begin
      err_code = iat_pkg::ST_SMALL;
    end
  end

  assign err = (err_code != iat_pkg::ST_OK);

  // output register
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_char || cmd.out_err) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_char) begin
      char_r   <= ch;
      last_r   <= (stp.ph == iat_pkg::G_DONE);
      status_r <= iat_pkg::ST_OK;
    end else if (cmd.out_err) begin
      char_r   <= 8'd0;
      last_r   <= 1'b1;
      status_r <= err_code;
    end
  end

  assign sts.done     = (gen_r.ph == iat_pkg::G_DONE);
  assign sts.err      = err;
  assign sts.out_free = out_free;

  assign out_valid    = out_valid_r;
  assign out_char_out = char_r;
  assign out_last     = last_r;
  assign out_status   = status_r;

endmodule
`default_nettype wire

>>> hdl/ip_address_to_text.sv
// ip_address_to_text: binary ipv4/ipv6 address to presentation text, one character a transfer
// one address at a time: in_stall holds off the next one through a length pass and then the output;
// characters leave at one a cycle while the output is not stalled; errors give one transfer
// reset: synchronous active-low rst_n clears the controller, generator and output valid
// depends on iat_pkg, iat_ctrl and iat_dp
`default_nettype none
module ip_address_to_text (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_action,
  input  wire logic [63:0] in_addr_high,
  input  wire logic [63:0] in_addr_low,
  input  wire logic [6:0]  in_dest_capacity,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_char_out,
  output logic             out_last,
  output logic [1:0]       out_status
);

  iat_pkg::dp_cmd_t cmd;
  iat_pkg::dp_sts_t sts;

  iat_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  iat_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_action        (in_action),
    .in_addr_high     (in_addr_high),
    .in_addr_low      (in_addr_low),
    .in_dest_capacity (in_dest_capacity),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_char_out     (out_char_out),
    .out_last         (out_last),
    .out_status       (out_status)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken again straight after a transfer");

  a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != iat_pkg::ST_OK) |-> (out_last && out_char_out == 8'd0))
    else $error("error result not a single zero character");

  a_text_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == iat_pkg::ST_OK) |-> (out_char_out != 8'd0))
    else $error("zero character in text");

endmodule
`default_nettype wire
